FILE: rtl/wsfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wsfp_pkg;

   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam logic [0:0] CSR_REQUIRE_MASK_WORD = 1'b0;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_HEADER  = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic ERR_UNMASKED = 1'b0;
   localparam logic ERR_OPCODE   = 1'b1;

   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   localparam logic [6:0] LEN_CODE_64 = 7'd127;
   localparam logic [6:0] LEN_CODE_16 = 7'd126;

   localparam logic [2:0] EXT_BYTES_64 = 3'd7;
   localparam logic [2:0] EXT_BYTES_16 = 3'd1;
   localparam logic [2:0] KEY_BYTES    = 3'd3;

   typedef enum logic [2:0] {
      PH_FIRST  = 3'd0,
      PH_SECOND = 3'd1,
      PH_EXTLEN = 3'd2,
      PH_KEY    = 3'd3,
      PH_BODY   = 3'd4
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       restart;
   } req_type;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [7:0]  payload_byte;
      logic        final_fragment;
      logic [3:0]  frame_opcode;
      logic [63:0] frame_length;
      logic        error_code;
      logic        frame_end;
   } rsp_type;

   function automatic logic opcode_ok(input logic [3:0] op);
      case (op)
         OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG: opcode_ok = 1'b1;
         default:                                        opcode_ok = 1'b0;
      endcase
   endfunction

endpackage

`default_nettype wire

FILE: rtl/websocket_frame_parser_unmasker_unit.sv
// a result beat is registered into the output slot, or into the skid slot while rsp stalls, when its byte is accepted
// throughput: one byte per cycle while req_ready is high; the parser state updates in the accepting cycle
// a two-slot result buffer (output register plus skid) lets bytes flow while rsp stalls;
// req_ready drops only when both slots are full
// reset: synchronous, clears the parse state and the result buffer, require_mask to 1
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_parser_unmasker_unit (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       req_valid,
   output logic                                      req_ready,
   input  wsfp_pkg::req_type                         req_payload,
   output logic                                      rsp_valid,
   input  wire                                       rsp_ready,
   output wsfp_pkg::rsp_type                         rsp_payload,
   input  wire                                       psel,
   input  wire                                       penable,
   input  wire                                       pwrite,
   input  wire [wsfp_pkg::CSR_ADDR_WIDTH-1:0]        paddr,
   input  wire [wsfp_pkg::CSR_DATA_WIDTH-1:0]        pwdata,
   output logic [wsfp_pkg::CSR_DATA_WIDTH-1:0]       prdata,
   output logic                                      pready
);

   logic                    require_mask_ff;
   wsfp_pkg::phase_type     phase_ff, phase_in;
   logic                    fin_ff, fin_in;
   logic [3:0]              opcode_ff, opcode_in;
   logic                    masked_ff, masked_in;
   logic [2:0]              hdr_count_ff, hdr_count_in;
   logic [63:0]             length_ff, length_in;
   logic [31:0]             key_ff, key_in;
   logic [63:0]             bytes_left_ff, bytes_left_in;
   logic [1:0]              key_index_ff, key_index_in;
   logic                    error_ff, error_in;

   logic                    out_valid_ff, out_valid_in;
   wsfp_pkg::rsp_type       out_data_ff, out_data_in;
   logic                    skid_valid_ff, skid_valid_in;
   wsfp_pkg::rsp_type       skid_data_ff, skid_data_in;

   logic                    accept;
   logic                    pop;
   logic                    push;
   wsfp_pkg::rsp_type       result;
   logic [7:0]              b;
   logic [7:0]              key_byte;
   logic [63:0]             left_dec;
   logic [63:0]             length_shift;
   wsfp_pkg::phase_type     phase_eff;
   logic                    error_eff;

   // configuration port
   assign pready = 1'b1;

   always_comb begin
      prdata = '0;
      if (paddr[2] == wsfp_pkg::CSR_REQUIRE_MASK_WORD) begin
         prdata[0] = require_mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         require_mask_ff <= 1'b1;
      end else if (psel && penable && pwrite && pready &&
                   paddr[2] == wsfp_pkg::CSR_REQUIRE_MASK_WORD) begin
         require_mask_ff <= pwdata[0];
      end
   end

   // handshake
   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_data_ff;
   assign pop       = out_valid_ff && rsp_ready;

   assign b            = req_payload.in_byte;
   assign left_dec     = (bytes_left_ff != 64'd0) ? bytes_left_ff - 64'd1 : bytes_left_ff;
   assign length_shift = {length_ff[55:0], b};

   always_comb begin
      case (key_index_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // parser
   always_comb begin
      phase_in      = phase_ff;
      fin_in        = fin_ff;
      opcode_in     = opcode_ff;
      masked_in     = masked_ff;
      hdr_count_in  = hdr_count_ff;
      length_in     = length_ff;
      key_in        = key_ff;
      bytes_left_in = bytes_left_ff;
      key_index_in  = key_index_ff;
      error_in      = error_ff;
      push          = 1'b0;
      result        = '0;
      phase_eff     = phase_ff;
      error_eff     = error_ff;

      if (req_payload.restart) begin
         phase_eff = wsfp_pkg::PH_FIRST;
         error_eff = 1'b0;
         error_in  = 1'b0;
      end

      result.final_fragment = fin_ff;
      result.frame_opcode   = opcode_ff;

      if (!error_eff) begin
         unique case (phase_eff)
            wsfp_pkg::PH_SECOND: begin
               masked_in = b[7];
               if (!b[7] && require_mask_ff) begin
                  error_in          = 1'b1;
                  phase_in          = wsfp_pkg::PH_FIRST;
                  push              = 1'b1;
                  result.out_kind   = wsfp_pkg::KIND_ERROR;
                  result.error_code = wsfp_pkg::ERR_UNMASKED;
               end else if (!wsfp_pkg::opcode_ok(opcode_ff)) begin
                  error_in          = 1'b1;
                  phase_in          = wsfp_pkg::PH_FIRST;
                  push              = 1'b1;
                  result.out_kind   = wsfp_pkg::KIND_ERROR;
                  result.error_code = wsfp_pkg::ERR_OPCODE;
               end else begin
                  key_in = '0;
                  if (b[6:0] == wsfp_pkg::LEN_CODE_64) begin
                     length_in    = '0;
                     hdr_count_in = wsfp_pkg::EXT_BYTES_64;
                     phase_in     = wsfp_pkg::PH_EXTLEN;
                  end else if (b[6:0] == wsfp_pkg::LEN_CODE_16) begin
                     length_in    = '0;
                     hdr_count_in = wsfp_pkg::EXT_BYTES_16;
                     phase_in     = wsfp_pkg::PH_EXTLEN;
                  end else begin
                     length_in = {57'd0, b[6:0]};
                     if (b[7]) begin
                        hdr_count_in = wsfp_pkg::KEY_BYTES;
                        phase_in     = wsfp_pkg::PH_KEY;
                     end else begin
                        push                = 1'b1;
                        result.out_kind     = wsfp_pkg::KIND_HEADER;
                        result.frame_length = {57'd0, b[6:0]};
                        result.frame_end    = (b[6:0] == 7'd0);
                        bytes_left_in       = {57'd0, b[6:0]};
                        key_index_in        = 2'd0;
                        phase_in            = (b[6:0] == 7'd0) ? wsfp_pkg::PH_FIRST
                                                               : wsfp_pkg::PH_BODY;
                     end
                  end
               end
            end
            wsfp_pkg::PH_EXTLEN: begin
               length_in = length_shift;
               if (hdr_count_ff != 3'd0) begin
                  hdr_count_in = hdr_count_ff - 3'd1;
               end else if (masked_ff) begin
                  hdr_count_in = wsfp_pkg::KEY_BYTES;
                  phase_in     = wsfp_pkg::PH_KEY;
               end else begin
                  push                = 1'b1;
                  result.out_kind     = wsfp_pkg::KIND_HEADER;
                  result.frame_length = length_shift;
                  result.frame_end    = (length_shift == 64'd0);
                  bytes_left_in       = length_shift;
                  key_index_in        = 2'd0;
                  phase_in            = (length_shift == 64'd0) ? wsfp_pkg::PH_FIRST
                                                                : wsfp_pkg::PH_BODY;
               end
            end
            wsfp_pkg::PH_KEY: begin
               key_in = {key_ff[23:0], b};
               if (hdr_count_ff != 3'd0) begin
                  hdr_count_in = hdr_count_ff - 3'd1;
               end else begin
                  push                = 1'b1;
                  result.out_kind     = wsfp_pkg::KIND_HEADER;
                  result.frame_length = length_ff;
                  result.frame_end    = (length_ff == 64'd0);
                  bytes_left_in       = length_ff;
                  key_index_in        = 2'd0;
                  phase_in            = (length_ff == 64'd0) ? wsfp_pkg::PH_FIRST
                                                             : wsfp_pkg::PH_BODY;
               end
            end
            wsfp_pkg::PH_BODY: begin
               push                = 1'b1;
               result.out_kind     = wsfp_pkg::KIND_PAYLOAD;
               result.payload_byte = masked_ff ? (b ^ key_byte) : b;
               result.frame_end    = (left_dec == 64'd0);
               key_index_in        = key_index_ff + 2'd1;
               bytes_left_in       = left_dec;
               if (left_dec == 64'd0) begin
                  phase_in = wsfp_pkg::PH_FIRST;
               end
            end
            default: begin
               fin_in        = b[7];
               opcode_in     = b[3:0];
               masked_in     = 1'b0;
               hdr_count_in  = '0;
               length_in     = '0;
               key_in        = '0;
               bytes_left_in = '0;
               key_index_in  = '0;
               phase_in      = wsfp_pkg::PH_SECOND;
            end
         endcase
      end
      if (!accept) begin
         push = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= wsfp_pkg::PH_FIRST;
         fin_ff        <= 1'b0;
         opcode_ff     <= '0;
         masked_ff     <= 1'b0;
         hdr_count_ff  <= '0;
         length_ff     <= '0;
         key_ff        <= '0;
         bytes_left_ff <= '0;
         key_index_ff  <= '0;
         error_ff      <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         fin_ff        <= fin_in;
         opcode_ff     <= opcode_in;
         masked_ff     <= masked_in;
         hdr_count_ff  <= hdr_count_in;
         length_ff     <= length_in;
         key_ff        <= key_in;
         bytes_left_ff <= bytes_left_in;
         key_index_ff  <= key_index_in;
         error_ff      <= error_in;
      end
   end

   // result buffer
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_data_in  = result;
            skid_valid_in = 1'b1;
         end else begin
            out_data_in  = result;
            out_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid slot holds a beat while the output slot is empty");

   a_error_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && error_ff && !req_payload.restart) |-> !push)
      else $error("result produced while the error is sticky");

   a_body_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == wsfp_pkg::PH_BODY) |-> (bytes_left_ff != 64'd0))
      else $error("body phase with no payload bytes left");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_ready) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid beat not moved to the output slot");

endmodule

`default_nettype wire

FILE: bench/websocket_frame_parser_unmasker_unit_test.sv
`timescale 1ns / 1ps

module websocket_frame_parser_unmasker_unit_test;

   typedef enum int {
      LEN_SHORT,
      LEN_MID,
      LEN_LONG
   } len_form_type;

   localparam int unsigned ADDR_WIDTH = wsfp_pkg::CSR_ADDR_WIDTH;

   localparam logic [wsfp_pkg::CSR_ADDR_WIDTH-1:0] REQUIRE_MASK_ADDR =
      ADDR_WIDTH'(4 * int'(wsfp_pkg::CSR_REQUIRE_MASK_WORD));
   localparam logic [wsfp_pkg::CSR_ADDR_WIDTH-1:0] UNMAPPED_ADDR =
      ADDR_WIDTH'(4 * (int'(wsfp_pkg::CSR_REQUIRE_MASK_WORD) + 1));

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   wire req_ready;
   wsfp_pkg::req_type req_payload = '0;
   wire rsp_valid;
   logic rsp_ready = 1'b0;
   wsfp_pkg::rsp_type rsp_payload;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [wsfp_pkg::CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [wsfp_pkg::CSR_DATA_WIDTH-1:0] pwdata = '0;
   wire [wsfp_pkg::CSR_DATA_WIDTH-1:0] prdata;
   wire pready;

   websocket_frame_parser_unmasker_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   // parser shadow state
   logic mask_required;
   wsfp_pkg::phase_type ph;
   logic fin_q;
   logic [3:0] op_q;
   logic masked_q;
   logic [2:0] hdr_cnt;
   logic [63:0] len_q;
   logic [31:0] key_q;
   logic [63:0] remain_q;
   logic [1:0] key_pos;
   logic err_q;

   wsfp_pkg::req_type byte_queue[$];
   wsfp_pkg::rsp_type frame_results[$];
   int queued_count = 0;
   int accepted_count = 0;
   int phase_bytes = 0;
   int mismatches = 0;
   bit needs_restart = 1'b0;
   logic long_hold_armed = 1'b0;

   int burst_left = 0;
   int gap_left = 0;
   int hold_left = 0;
   bit long_hold_done = 1'b0;
   int rx_mode = 0;
   int rx_mode_left = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void clear_parse();
      ph = wsfp_pkg::PH_FIRST;
      fin_q = 1'b0;
      op_q = '0;
      masked_q = 1'b0;
      hdr_cnt = '0;
      len_q = '0;
      key_q = '0;
      remain_q = '0;
      key_pos = '0;
      err_q = 1'b0;
   endfunction

   function automatic wsfp_pkg::rsp_type make_result(input logic [1:0] kind,
                                                     input logic [7:0] pb,
                                                     input logic [63:0] len, input logic ec,
                                                     input logic fend);
      wsfp_pkg::rsp_type r;
      r.out_kind = kind;
      r.payload_byte = pb;
      r.final_fragment = fin_q;
      r.frame_opcode = op_q;
      r.frame_length = len;
      r.error_code = ec;
      r.frame_end = fend;
      return r;
   endfunction

   function automatic wsfp_pkg::rsp_type flag_error(input logic ec);
      err_q = 1'b1;
      ph = wsfp_pkg::PH_FIRST;
      return make_result(wsfp_pkg::KIND_ERROR, 8'h00, 64'd0, ec, 1'b0);
   endfunction

   function automatic wsfp_pkg::rsp_type finish_header();
      logic empty;
      empty = (len_q == 64'd0);
      remain_q = len_q;
      key_pos = '0;
      ph = empty ? wsfp_pkg::PH_FIRST : wsfp_pkg::PH_BODY;
      return make_result(wsfp_pkg::KIND_HEADER, 8'h00, len_q, 1'b0, empty);
   endfunction

   function automatic bit parse_byte(input wsfp_pkg::req_type item,
                                     output wsfp_pkg::rsp_type res);
      logic [7:0] b;
      logic [7:0] k;
      logic [6:0] code;
      logic last;
      b = item.in_byte;
      res = '0;
      if (item.restart) clear_parse();
      if (err_q) return 1'b0;
      case (ph)
         wsfp_pkg::PH_SECOND: begin
            code = b[6:0];
            masked_q = b[7];
            if (!masked_q && mask_required) begin
               res = flag_error(wsfp_pkg::ERR_UNMASKED);
               return 1'b1;
            end
            if (!(op_q inside {wsfp_pkg::OP_TEXT, wsfp_pkg::OP_BINARY, wsfp_pkg::OP_CLOSE,
                               wsfp_pkg::OP_PING, wsfp_pkg::OP_PONG})) begin
               res = flag_error(wsfp_pkg::ERR_OPCODE);
               return 1'b1;
            end
            len_q = '0;
            key_q = '0;
            if (code == wsfp_pkg::LEN_CODE_64 || code == wsfp_pkg::LEN_CODE_16) begin
               hdr_cnt = (code == wsfp_pkg::LEN_CODE_64) ? wsfp_pkg::EXT_BYTES_64
                                                         : wsfp_pkg::EXT_BYTES_16;
               ph = wsfp_pkg::PH_EXTLEN;
               return 1'b0;
            end
            len_q = 64'(code);
            if (masked_q) begin
               hdr_cnt = wsfp_pkg::KEY_BYTES;
               ph = wsfp_pkg::PH_KEY;
               return 1'b0;
            end
            res = finish_header();
            return 1'b1;
         end
         wsfp_pkg::PH_EXTLEN: begin
            len_q = {len_q[55:0], b};
            if (hdr_cnt != 0) begin
               hdr_cnt = hdr_cnt - 3'd1;
               return 1'b0;
            end
            if (masked_q) begin
               hdr_cnt = wsfp_pkg::KEY_BYTES;
               ph = wsfp_pkg::PH_KEY;
               return 1'b0;
            end
            res = finish_header();
            return 1'b1;
         end
         wsfp_pkg::PH_KEY: begin
            key_q = {key_q[23:0], b};
            if (hdr_cnt != 0) begin
               hdr_cnt = hdr_cnt - 3'd1;
               return 1'b0;
            end
            res = finish_header();
            return 1'b1;
         end
         wsfp_pkg::PH_BODY: begin
            k = masked_q ? 8'(key_q >> (8 * (3 - int'(key_pos)))) : 8'h00;
            key_pos = key_pos + 2'd1;
            if (remain_q != 0) remain_q = remain_q - 64'd1;
            last = (remain_q == 0);
            if (last) ph = wsfp_pkg::PH_FIRST;
            res = make_result(wsfp_pkg::KIND_PAYLOAD, b ^ k, 64'd0, 1'b0, last);
            return 1'b1;
         end
         default: begin
            fin_q = b[7];
            op_q = b[3:0];
            masked_q = 1'b0;
            hdr_cnt = '0;
            len_q = '0;
            key_q = '0;
            remain_q = '0;
            key_pos = '0;
            ph = wsfp_pkg::PH_SECOND;
            return 1'b0;
         end
      endcase
   endfunction

   task automatic add_byte(input logic [7:0] b, input logic rs);
      wsfp_pkg::req_type it;
      it.in_byte = b;
      it.restart = rs;
      byte_queue = {byte_queue, it};
      queued_count++;
      phase_bytes++;
   endtask

   task automatic add_frame(input logic rs, input logic [7:0] first, input logic masked,
                            input len_form_type form, input logic [63:0] len,
                            input int body);
      logic [31:0] key;
      key = $urandom;
      add_byte(first, rs);
      case (form)
         LEN_SHORT: add_byte({masked, len[6:0]}, 1'b0);
         LEN_MID: begin
            add_byte({masked, wsfp_pkg::LEN_CODE_16}, 1'b0);
            for (int i = 1; i >= 0; i--) add_byte(len[8*i +: 8], 1'b0);
         end
         default: begin
            add_byte({masked, wsfp_pkg::LEN_CODE_64}, 1'b0);
            for (int i = 7; i >= 0; i--) add_byte(len[8*i +: 8], 1'b0);
         end
      endcase
      if (masked) begin
         for (int i = 3; i >= 0; i--) add_byte(key[8*i +: 8], 1'b0);
      end
      for (int i = 0; i < body; i++) add_byte(8'($urandom), 1'b0);
   endtask

   task automatic add_random_frame(input logic mask_on);
      logic [3:0] op;
      bit op_good;
      logic masked;
      len_form_type form;
      logic [63:0] len;
      int body;
      int r;
      op_good = ($urandom_range(0, 99) < 88);
      if (op_good) begin
         case ($urandom_range(0, 4))
            0: op = wsfp_pkg::OP_TEXT;
            1: op = wsfp_pkg::OP_BINARY;
            2: op = wsfp_pkg::OP_CLOSE;
            3: op = wsfp_pkg::OP_PING;
            default: op = wsfp_pkg::OP_PONG;
         endcase
      end else begin
         op = 4'($urandom);
      end
      masked = ($urandom_range(0, 9) != 0);
      r = $urandom_range(0, 99);
      form = (r < 60) ? LEN_SHORT : (r < 85) ? LEN_MID : LEN_LONG;
      r = $urandom_range(0, 99);
      case (form)
         LEN_SHORT: len = (r < 80) ? 64'($urandom_range(0, 24))
                                   : 64'($urandom_range(0, 125));
         LEN_MID: len = (r < 70) ? 64'($urandom_range(0, 40))
                                 : 64'($urandom_range(0, 65535));
         default: len = (r < 60) ? 64'($urandom_range(0, 40)) : {$urandom, $urandom};
      endcase
      body = (len <= 160) ? int'(len) : int'($urandom_range(0, 12));
      if (len != 0 && len <= 160 && $urandom_range(0, 19) == 0)
         body = int'($urandom_range(0, int'(len) - 1));
      add_frame(needs_restart || $urandom_range(0, 4) == 0,
                {1'($urandom), 3'($urandom), op}, masked, form, len, body);
      needs_restart = (body < len) || (!masked && mask_on) || !op_good;
   endtask

   task automatic add_random_traffic(input int target, input logic mask_on);
      phase_bytes = 0;
      while (phase_bytes < target) begin
         if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom), $urandom_range(0, 3) == 0);
            needs_restart = 1'b1;
         end else begin
            add_random_frame(mask_on);
         end
      end
   endtask

   task automatic wait_idle();
      while (accepted_count != queued_count || frame_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [wsfp_pkg::CSR_ADDR_WIDTH-1:0] addr,
                            input logic [wsfp_pkg::CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   // sender
   always @(posedge clock) begin
      wsfp_pkg::rsp_type res;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            if (parse_byte(req_payload, res)) frame_results = {frame_results, res};
            accepted_count++;
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (byte_queue.size() != 0) begin
            req_payload <= byte_queue.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 48);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (long_hold_armed && !long_hold_done) begin
         long_hold_done = 1'b1;
         hold_left = 300;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(8, 80);
         end
         rx_mode_left--;
         case (rx_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // result checker
   always @(posedge clock) begin
      wsfp_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_results.size() == 0) begin
            $error("result beat with nothing expected: %0h", rsp_payload);
            mismatches++;
         end else begin
            want = frame_results.pop_front();
            check_field("out_kind", want.out_kind, rsp_payload.out_kind);
            check_field("payload_byte", want.payload_byte, rsp_payload.payload_byte);
            check_field("final_fragment", want.final_fragment, rsp_payload.final_fragment);
            check_field("frame_opcode", want.frame_opcode, rsp_payload.frame_opcode);
            check_field("frame_length", want.frame_length, rsp_payload.frame_length);
            check_field("error_code", want.error_code, rsp_payload.error_code);
            check_field("frame_end", want.frame_end, rsp_payload.frame_end);
         end
      end
   end

   initial begin
      clear_parse();
      mask_required = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // unmasked frame rejected, then ignored byte while the error holds
      add_byte(8'h81, 1'b0);
      add_byte(8'h05, 1'b0);
      add_byte(8'h00, 1'b0);
      // zero-length pong
      add_frame(1'b1, 8'h8A, 1'b1, LEN_SHORT, 64'd0, 0);
      // reserved bits, bad opcode and no mask: mask error wins
      add_byte(8'h73, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h0F, 1'b1);
      add_byte(8'h81, 1'b0);
      add_frame(1'b1, 8'hF2, 1'b1, LEN_MID, 64'd1, 1);
      // huge 64-bit length
      add_frame(1'b0, 8'h09, 1'b1, LEN_LONG, '1, 0);
      add_frame(1'b1, 8'h88, 1'b1, LEN_SHORT, 64'd1, 1);

      long_hold_armed <= 1'b1;
      needs_restart = 1'b0;
      add_random_traffic(400, 1'b1);
      wait_idle();

      csr_write(UNMAPPED_ADDR, '0);
      csr_write(REQUIRE_MASK_ADDR, '0);
      mask_required = 1'b0;
      add_frame(1'b1, 8'h81, 1'b0, LEN_SHORT, 64'd3, 3);
      add_frame(1'b0, 8'h82, 1'b1, LEN_SHORT, 64'd2, 2);
      needs_restart = 1'b0;
      add_random_traffic(350, 1'b0);
      wait_idle();

      csr_write(REQUIRE_MASK_ADDR, 32'd1);
      mask_required = 1'b1;
      needs_restart = 1'b1;
      add_random_traffic(350, 1'b1);
      wait_idle();

      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("FAILURE");
      $finish;
   end

endmodule

FILE: websocket_frame_parser_unmasker_unit.f
rtl/wsfp_pkg.sv
rtl/websocket_frame_parser_unmasker_unit.sv
bench/websocket_frame_parser_unmasker_unit_test.sv
